// ----- design/nif_pkg.sv -----
// Package of the normalised 3x3 image filter: state codes, register indexes,
// reset values and the coefficient extraction helper.
// Self-contained; used by normalized_3x3_image_filter_unit.
`timescale 1ns / 1ps
package nif_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int COEF_BITS      = 16;
    localparam int KROW_BITS      = 48;
    localparam int SUM_BITS       = 20;
    localparam int ACC_BITS       = 30;
    localparam int NUM_BITS       = 36;
    localparam int DEN_BITS       = 26;

    localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_KERNEL_TOP    = 3'd2;
    localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd3;
    localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd4;

    localparam logic [10:0]          RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [12:0]          RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [KROW_BITS-1:0] RST_KERNEL_EDGE  = '0;
    localparam logic [KROW_BITS-1:0] RST_KERNEL_MID   = 48'd16777216;
    localparam logic [SUM_BITS-1:0]  RST_POS_SUM      = 20'd256;

    localparam logic [0:0] REQ_PIXEL = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FLUSH,
        ST_SCALE,
        ST_CLAMP,
        ST_DIVIDE,
        ST_FINISH
    } nif_state_t;

    function automatic logic signed [COEF_BITS-1:0] nif_coef(
        input logic [KROW_BITS-1:0] row,
        input logic [1:0]           kx
    );
        logic signed [COEF_BITS-1:0] c;
        c = $signed(row[kx*COEF_BITS +: COEF_BITS]);
        return c;
    endfunction

endpackage

// ----- design/normalized_3x3_image_filter_unit.sv -----
// Normalised 3x3 image filter: line store, sequential tap reader, scaling
// and an 8-step quotient unit. Depends on nif_pkg.
//
// An item that produces no result leaves the block in ST_IDLE, ready for the
// next item. An item that produces a result holds the input through these
// steps: the accept, nine single-port reads of the row memory with a
// multiply-accumulate behind them, a flush for the last product, scaling in
// ST_SCALE and ST_CLAMP, up to eight restoring-division steps and the load
// of the output register, which waits while an earlier result is still held
// by m_ready. Results lag the pixel stream by one row plus one pixel. Reset
// is synchronous and active low; the row memory is not cleared, and only
// entries written in the current frame are used.
`timescale 1ns / 1ps
module normalized_3x3_image_filter_unit #(
    parameter int MAX_WIDTH  = nif_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = nif_pkg::DEF_MAX_HEIGHT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [47:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_grey_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_grey_out,
    output logic        m_frame_end,
    output logic        m_kernel_degenerate
);
    import nif_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = RW + WW + 1;
    localparam int AW = CW + 2;

    nif_state_t state_reg, state_next;

    logic [10:0]           image_width_reg;
    logic [12:0]           image_height_reg;
    logic [KROW_BITS-1:0]  krow_top_reg, krow_mid_reg, krow_bot_reg;
    logic [SUM_BITS-1:0]   pos_sum_reg, pos_sum_next;
    logic [SUM_BITS-1:0]   neg_sum_reg, neg_sum_next;

    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [RW-1:0] in_row_reg, out_row_reg;
    logic [1:0]    in_mod_reg, out_mod_reg;
    logic          input_done_reg;

    logic [1:0]    ky_reg, kx_reg;
    logic          rd_pend_reg, tap_ok_reg;
    logic signed [COEF_BITS-1:0] coef_d_reg;
    logic [7:0]    rd_data_reg;
    logic signed [ACC_BITS-1:0] acc_reg;
    logic [3:0]    n_reg;
    logic signed [SUM_BITS+5-1:0] t_reg;
    logic [DEN_BITS-1:0] den_reg;
    logic signed [NUM_BITS-1:0] rem_reg;
    logic [2:0]    bit_reg;
    logic [7:0]    quo_reg;

    logic       m_valid_reg, frame_end_reg, degen_reg;
    logic [7:0] grey_out_reg;

    logic [7:0] row_mem [0:(1<<AW)-1];

    logic [WW-1:0] w_eff;
    logic [HW-1:0] h_eff;
    logic [PW-1:0] in_pos, out_pos;
    logic          accept, is_pixel, emit_now, out_free, last_out;
    logic          tap_ok, rd_en, in_col_wrap, in_row_wrap, out_col_wrap;
    logic [1:0]    row_sel, in_mod_adv, out_mod_adv, out_mod_prev;
    logic [AW-1:0] rd_addr;
    logic [KROW_BITS-1:0] krow_sel;
    logic signed [NUM_BITS-1:0] num_w, den_sh, rem_sub;
    logic          degen;

    always_comb begin
        if (image_width_reg == '0) begin
            w_eff = WW'(1);
        end else if (32'(image_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(image_width_reg);
        end
        if (image_height_reg == '0) begin
            h_eff = HW'(1);
        end else if (32'(image_height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = HW'(MAX_HEIGHT);
        end else begin
            h_eff = HW'(image_height_reg);
        end
    end

    // Positive and negative kernel sums, registered from the kernel row registers.
    always_comb begin
        logic signed [SUM_BITS-1:0] c;
        pos_sum_next = '0;
        neg_sum_next = '0;
        for (int k = 0; k < 9; k++) begin
            c = SUM_BITS'(nif_coef(k < 3 ? krow_top_reg : (k < 6 ? krow_mid_reg : krow_bot_reg),
                                   2'(k % 3)));
            if (c > 0) begin
                pos_sum_next = pos_sum_next + c;
            end else begin
                neg_sum_next = neg_sum_next + c;
            end
        end
    end

    // Raster positions of the next input and the next output at the current width.
    assign in_pos  = PW'(in_row_reg) * PW'(w_eff) + PW'(in_col_reg);
    assign out_pos = PW'(out_row_reg) * PW'(w_eff) + PW'(out_col_reg);

    assign degen    = (pos_sum_reg == neg_sum_reg);
    assign is_pixel = (s_req_type == REQ_PIXEL);
    assign out_free = !m_valid_reg || m_ready;
    assign emit_now = input_done_reg
                      || (is_pixel && (32'(in_pos) >= 32'(out_pos) + 32'(w_eff) + 32'd1));

    assign in_col_wrap  = 32'(in_col_reg) + 32'd1 >= 32'(w_eff);
    assign in_row_wrap  = 32'(in_row_reg) + 32'd1 >= 32'(h_eff);
    assign out_col_wrap = 32'(out_col_reg) + 32'd1 >= 32'(w_eff);
    assign last_out     = out_col_wrap && (32'(out_row_reg) + 32'd1 >= 32'(h_eff));

    assign in_mod_adv   = (in_mod_reg == 2'd2) ? 2'd0 : in_mod_reg + 2'd1;
    assign out_mod_adv  = (out_mod_reg == 2'd2) ? 2'd0 : out_mod_reg + 2'd1;
    assign out_mod_prev = (out_mod_reg == 2'd0) ? 2'd2 : out_mod_reg - 2'd1;

    // Neighbour of the current tap is inside the frame.
    always_comb begin
        int rr, cc;
        rr = int'(out_row_reg) + int'(ky_reg) - 1;
        cc = int'(out_col_reg) + int'(kx_reg) - 1;
        tap_ok = (rr >= 0) && (rr < int'(h_eff)) && (cc >= 0) && (cc < int'(w_eff));
        case (ky_reg)
            2'd0:    begin row_sel = out_mod_prev; krow_sel = krow_top_reg; end
            2'd1:    begin row_sel = out_mod_reg;  krow_sel = krow_mid_reg; end
            default: begin row_sel = out_mod_adv;  krow_sel = krow_bot_reg; end
        endcase
    end

    assign rd_addr = {row_sel, out_col_reg + CW'(kx_reg) - CW'(1)};

    assign num_w   = NUM_BITS'(acc_reg) - ((NUM_BITS'(t_reg) <<< 8) - NUM_BITS'(t_reg));
    assign den_sh  = $signed(NUM_BITS'(den_reg) << bit_reg);
    assign rem_sub = rem_reg - den_sh;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && emit_now) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                if (ky_reg == 2'd2 && kx_reg == 2'd2) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:  state_next = ST_SCALE;
            ST_SCALE:  state_next = ST_CLAMP;
            ST_CLAMP: begin
                if (degen || n_reg == '0 || num_w < 0
                        || num_w >= $signed(NUM_BITS'(den_reg) << 8)) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (bit_reg == '0) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and memory controls.
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_READ: rd_en   = 1'b1;
            default: begin
                s_ready = 1'b0;
                rd_en   = 1'b0;
            end
        endcase
    end

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (accept && !input_done_reg && is_pixel) begin
            row_mem[{in_mod_reg, in_col_reg}] <= s_grey_in;
        end
        if (rd_en) begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            image_width_reg  <= RST_IMAGE_WIDTH;
            image_height_reg <= RST_IMAGE_HEIGHT;
            krow_top_reg     <= RST_KERNEL_EDGE;
            krow_mid_reg     <= RST_KERNEL_MID;
            krow_bot_reg     <= RST_KERNEL_EDGE;
            pos_sum_reg      <= RST_POS_SUM;
            neg_sum_reg      <= '0;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            in_mod_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            out_mod_reg      <= '0;
            input_done_reg   <= 1'b0;
            ky_reg           <= '0;
            kx_reg           <= '0;
            rd_pend_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pos_sum_reg <= pos_sum_next;
            neg_sum_reg <= neg_sum_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_IMAGE_WIDTH:   image_width_reg  <= cfg_wdata[10:0];
                    REG_IMAGE_HEIGHT:  image_height_reg <= cfg_wdata[12:0];
                    REG_KERNEL_TOP:    krow_top_reg     <= cfg_wdata;
                    REG_KERNEL_MIDDLE: krow_mid_reg     <= cfg_wdata;
                    REG_KERNEL_BOTTOM: krow_bot_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            rd_pend_reg <= rd_en;
            if (accept && !input_done_reg && is_pixel) begin
                if (in_col_wrap) begin
                    in_col_reg <= '0;
                    if (in_row_wrap) begin
                        input_done_reg <= 1'b1;
                    end else begin
                        in_row_reg <= in_row_reg + RW'(1);
                        in_mod_reg <= in_mod_adv;
                    end
                end else begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (accept) begin
                ky_reg <= '0;
                kx_reg <= '0;
            end
            if (state_reg == ST_READ) begin
                if (kx_reg == 2'd2) begin
                    kx_reg <= '0;
                    ky_reg <= ky_reg + 2'd1;
                end else begin
                    kx_reg <= kx_reg + 2'd1;
                end
            end
            if (state_reg == ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
                if (last_out) begin
                    in_col_reg     <= '0;
                    in_row_reg     <= '0;
                    in_mod_reg     <= '0;
                    out_col_reg    <= '0;
                    out_row_reg    <= '0;
                    out_mod_reg    <= '0;
                    input_done_reg <= 1'b0;
                end else begin
                    if (out_col_wrap) begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + RW'(1);
                        out_mod_reg <= out_mod_adv;
                    end else begin
                        out_col_reg <= out_col_reg + CW'(1);
                    end
                end
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            acc_reg <= '0;
            n_reg   <= '0;
        end
        if (state_reg == ST_READ) begin
            tap_ok_reg <= tap_ok;
            coef_d_reg <= nif_coef(krow_sel, kx_reg);
            if (tap_ok) begin
                n_reg <= n_reg + 4'd1;
            end
        end
        if (rd_pend_reg && tap_ok_reg) begin
            acc_reg <= acc_reg + ACC_BITS'($signed({1'b0, rd_data_reg}) * coef_d_reg);
        end
        if (state_reg == ST_SCALE) begin
            t_reg   <= $signed({1'b0, n_reg}) * $signed(neg_sum_reg);
            den_reg <= DEN_BITS'(n_reg * SUM_BITS'(pos_sum_reg - neg_sum_reg));
        end
        if (state_reg == ST_CLAMP) begin
            rem_reg <= num_w;
            bit_reg <= 3'd7;
            if (!degen && n_reg != '0 && num_w >= 0
                    && num_w >= $signed(NUM_BITS'(den_reg) << 8)) begin
                quo_reg <= 8'hFF;
            end else begin
                quo_reg <= '0;
            end
        end
        if (state_reg == ST_DIVIDE) begin
            if (rem_sub >= 0) begin
                rem_reg          <= rem_sub;
                quo_reg[bit_reg] <= 1'b1;
            end
            bit_reg <= bit_reg - 3'd1;
        end
        if (state_reg == ST_FINISH && out_free) begin
            grey_out_reg  <= quo_reg;
            frame_end_reg <= last_out;
            degen_reg     <= degen;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_grey_out          = grey_out_reg;
    assign m_frame_end         = frame_end_reg;
    assign m_kernel_degenerate = degen_reg;

`ifndef SYNTHESIS
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free && last_out)
            |=> (in_col_reg == '0 && in_row_reg == '0 && !input_done_reg))
        else $error("counters not cleared after the last result of a frame");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && degen_reg) |-> (grey_out_reg == '0))
        else $error("degenerate kernel result carries a non-zero pixel");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FLUSH) |-> (n_reg <= 4'd9 && rd_pend_reg))
        else $error("tap sequence out of step with the memory read");
`endif

endmodule
